// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, skipped while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/gfli_pkg.sv
`default_nettype none

package gfli_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_GAP_DEF  = 63;
  localparam int SAMPLE_W_DEF = 16;

  // Gap counter width, fixed by the pending gap state
  localparam int GAP_W = 6;

  // Source of an emitted result
  typedef enum logic [1:0] {
    SRC_FILL,
    SRC_COPY,
    SRC_HOLD,
    SRC_SAMPLE
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the input transaction
    logic gap_step;    // missing sample: grow gap, count = new gap
    logic gap_load;    // good sample: count = pending gap
    logic div_start;   // start delta / (gap + 1)
    logic div_fix;     // turn divider result into floor step terms
    logic emit;        // load the output register
    src_t sel;         // what to emit
    logic ovf;         // overflow flag for held results
    logic last;        // last result of this input
    logic upd_prev;    // good sample becomes the last good value
    logic clr_gap;     // pending gap back to zero
    logic clr_series;  // series end: series state back to reset
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic miss;        // captured sample is missing
    logic last_in;     // captured sample ends the series
    logic gap_full;    // gap + 1 reaches the maximum gap
    logic gap_zero;    // no pending gap
    logic have_prev;   // a good value exists in this series
    logic div_done;    // divider result valid this cycle
    logic cnt_one;     // one gap result left
    logic slot_free;   // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/gfli_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module gfli_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quo,
  output logic      [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   partial;
  logic             fits;

  // Trial subtraction on the shifted remainder
  assign partial = {rem, quo[DVD_W-1]};
  assign fits    = partial >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? DVS_W'(partial - {1'b0, dvs}) : partial[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gfli_dp.sv
`default_nettype none

`include "assert_macros.svh"

module gfli_dp
  import gfli_pkg::*;
#(
  parameter int MAX_GAP      = MAX_GAP_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                    in_missing,
  input  wire logic                    in_end,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [SAMPLE_WIDTH-1:0] out_value,
  output logic                         out_filled,
  output logic                         out_unfilled,
  output logic                         out_overflow,
  output logic                         out_last
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int DW = GAP_W + 1;

  // Series state
  logic signed [SW-1:0]    prev_good;
  logic                    have_prev;
  logic        [GAP_W-1:0] pending_gap;

  // Captured input
  logic signed [SW-1:0] next_smp;
  logic                 in_miss_q;
  logic                 in_end_q;

  // Gap walk
  logic        [GAP_W-1:0] cnt;
  logic signed [SW:0]      qd;
  logic        [DW-1:0]    rd;
  logic signed [SW:0]      q;
  logic        [DW-1:0]    r;

  logic        [DW-1:0]    d;
  logic signed [SW:0]      delta;
  logic        [SW:0]      delta_mag;
  logic                    div_done;
  logic        [SW-1:0]    div_quo;
  logic        [DW-1:0]    div_rem;
  logic        [DW:0]      r_sum;
  logic                    r_wrap;
  logic        [DW-1:0]    r_new;
  logic signed [SW:0]      q_new;
  logic signed [SW:0]      q_trunc;
  logic                    slot_free;

  // Gap length plus one is the divisor
  assign d     = DW'(pending_gap) + DW'(1);
  assign delta = {next_smp[SW-1], next_smp} - {prev_good[SW-1], prev_good};
  assign delta_mag = delta[SW] ? -delta : delta;

  gfli_div #(
    .DVD_W(SW),
    .DVS_W(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(delta_mag[SW-1:0]),
    .divisor (d),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // Next interpolated point: floor quotient/remainder step, then truncate toward zero
  assign r_sum   = {1'b0, r} + {1'b0, rd};
  assign r_wrap  = r_sum >= {1'b0, d};
  assign r_new   = r_wrap ? DW'(r_sum - {1'b0, d}) : r_sum[DW-1:0];
  assign q_new   = q + qd + {{SW{1'b0}}, r_wrap};
  assign q_trunc = q_new + {{SW{1'b0}}, (q_new[SW] && (r_new != '0))};

  assign slot_free = !out_valid || out_ready;

  // Status
  always_comb begin
    sts           = '0;
    sts.miss      = in_miss_q;
    sts.last_in   = in_end_q;
    sts.gap_full  = d >= DW'(MAX_GAP);
    sts.gap_zero  = pending_gap == '0;
    sts.have_prev = have_prev;
    sts.div_done  = div_done;
    sts.cnt_one   = cnt == GAP_W'(1);
    sts.slot_free = slot_free;
  end

  // Series state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_good   <= '0;
      have_prev   <= 1'b0;
      pending_gap <= '0;
    end else if (cmd.clr_series) begin
      prev_good   <= '0;
      have_prev   <= 1'b0;
      pending_gap <= '0;
    end else if (cmd.upd_prev) begin
      prev_good   <= next_smp;
      have_prev   <= 1'b1;
      pending_gap <= '0;
    end else if (cmd.clr_gap) begin
      pending_gap <= '0;
    end else if (cmd.gap_step) begin
      pending_gap <= pending_gap + GAP_W'(1);
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_miss_q <= 1'b0;
      in_end_q  <= 1'b0;
    end else if (cmd.load) begin
      in_miss_q <= in_missing;
      in_end_q  <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      next_smp <= in_sample;
    end
  end

  // Remaining gap results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.gap_step) begin
      cnt <= pending_gap + GAP_W'(1);
    end else if (cmd.gap_load) begin
      cnt <= pending_gap;
    end else if (cmd.emit && (cmd.sel != SRC_SAMPLE)) begin
      cnt <= cnt - GAP_W'(1);
    end
  end

  // Floor step terms and running quotient/remainder
  always_ff @(posedge clk) begin
    if (cmd.div_fix) begin
      if (!delta[SW]) begin
        qd <= {1'b0, div_quo};
        rd <= div_rem;
      end else if (div_rem != '0) begin
        qd <= ~{1'b0, div_quo};
        rd <= d - div_rem;
      end else begin
        qd <= -{1'b0, div_quo};
        rd <= '0;
      end
      q <= {prev_good[SW-1], prev_good};
      r <= '0;
    end else if (cmd.emit && (cmd.sel == SRC_FILL)) begin
      q <= q_new;
      r <= r_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last     <= cmd.last;
      out_overflow <= 1'b0;
      out_unfilled <= 1'b0;
      case (cmd.sel)
        SRC_FILL: begin
          out_value  <= q_trunc[SW-1:0];
          out_filled <= 1'b1;
        end
        SRC_COPY: begin
          out_value  <= next_smp;
          out_filled <= 1'b1;
        end
        SRC_HOLD: begin
          out_value    <= have_prev ? prev_good : '0;
          out_filled   <= have_prev;
          out_unfilled <= !have_prev;
          out_overflow <= cmd.ovf;
        end
        SRC_SAMPLE: begin
          out_value  <= next_smp;
          out_filled <= 1'b0;
        end
        default: begin
          out_value  <= next_smp;
          out_filled <= 1'b0;
        end
      endcase
    end
  end

  `CHK_IMPLY(a_prev_zero_without_good, clk, rst, !have_prev, prev_good == '0)
  `CHK_IMPLY(a_gap_below_max, clk, rst, 1'b1, pending_gap <= GAP_W'(MAX_GAP))
  `CHK_NEXT(a_good_clears_gap, clk, rst, cmd.upd_prev && !cmd.clr_series, have_prev && (pending_gap == '0))

endmodule

`default_nettype wire

// File: hw/rtl/gfli_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module gfli_ctrl
  import gfli_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_FILL,
    ST_COPY,
    ST_HOLD,
    ST_SAMPLE
  } state_t;

  state_t state;
  state_t state_next;
  logic   ovf;

  assign in_ready = state == ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SRC_SAMPLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.miss) begin
          cmd.gap_step = 1'b1;
          state_next   = (sts.gap_full || sts.last_in) ? ST_HOLD : ST_IDLE;
        end else if (sts.gap_zero) begin
          // plain good sample, straight out when the slot is free
          if (sts.slot_free) begin
            cmd.emit       = 1'b1;
            cmd.sel        = SRC_SAMPLE;
            cmd.last       = 1'b1;
            cmd.upd_prev   = 1'b1;
            cmd.clr_series = sts.last_in;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_SAMPLE;
          end
        end else begin
          cmd.gap_load = 1'b1;
          if (sts.have_prev) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_COPY;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_fix = 1'b1;
          state_next  = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SRC_FILL;
          if (sts.cnt_one) begin
            state_next = ST_SAMPLE;
          end
        end
      end
      ST_COPY: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SRC_COPY;
          if (sts.cnt_one) begin
            state_next = ST_SAMPLE;
          end
        end
      end
      ST_HOLD: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SRC_HOLD;
          cmd.ovf  = ovf;
          cmd.last = sts.cnt_one;
          if (sts.cnt_one) begin
            cmd.clr_gap    = 1'b1;
            cmd.clr_series = sts.last_in;
            state_next     = ST_IDLE;
          end
        end
      end
      ST_SAMPLE: begin
        if (sts.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.sel        = SRC_SAMPLE;
          cmd.last       = 1'b1;
          cmd.upd_prev   = 1'b1;
          cmd.clr_series = sts.last_in;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and overflow flag for a held flush
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE) begin
        ovf <= sts.gap_full;
      end
    end
  end

  `CHK_IMPLY(a_emit_needs_slot, clk, rst, cmd.emit, sts.slot_free)
  `CHK_IMPLY(a_div_needs_prev, clk, rst, cmd.div_start, sts.have_prev && !sts.gap_zero)
  `CHK_NEXT(a_load_then_decide, clk, rst, cmd.load, state == ST_DECIDE)

endmodule

`default_nettype wire

// File: hw/rtl/gap_fill_linear_interpolation_core.sv
`default_nettype none

// Channel   Dir  tdata                     tuser                              tlast
// s_axis    in   sample                    missing                            series_end
// m_axis    out  value                     was_filled, unfilled, overflow     last_of_run
//
// Good sample, no pending gap: accepted, then emitted as soon as the output slot is free.
// Missing sample that opens no flush: accepted and added to the pending gap, no result.
// Good sample after g missing: one divide of (next - prev) by g + 1 in the bit-serial divider,
// then one result per cycle while the output is free (copies, no divide, with no earlier value).
// Held or unfilled flush of g samples: g results. Output stalls hold the sequencer.
// rst is synchronous; the series state comes up empty.

module gap_fill_linear_interpolation_core
  import gfli_pkg::*;
#(
  parameter int MAX_GAP      = MAX_GAP_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  wire logic               s_axis_tuser,   // missing
  input  wire logic               s_axis_tlast,   // series_end
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [TDATA_W-1:0] m_axis_tdata,   // [SAMPLE_WIDTH-1:0] value
  output logic      [2:0]         m_axis_tuser,   // was_filled, unfilled, overflow
  output logic                    m_axis_tlast    // last_of_run
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic [SAMPLE_WIDTH-1:0] out_value;
  logic                    out_filled;
  logic                    out_unfilled;
  logic                    out_overflow;

  gfli_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  gfli_dp #(
    .MAX_GAP     (MAX_GAP),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_missing  (s_axis_tuser),
    .in_end      (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_value   (out_value),
    .out_filled  (out_filled),
    .out_unfilled(out_unfilled),
    .out_overflow(out_overflow),
    .out_last    (m_axis_tlast)
  );

  // Pack result fields, zero pad to whole bytes
  assign m_axis_tdata = TDATA_W'(out_value);
  assign m_axis_tuser = {out_overflow, out_unfilled, out_filled};

endmodule

`default_nettype wire

// File: sim/gap_fill_linear_interpolation_core_test.sv
`default_nettype none

module gap_fill_linear_interpolation_core_test;
  import gfli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = ((SAMPLE_W_DEF + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_TAIL  = 150;   // covers the longest divide plus a full gap burst

  typedef struct packed {
    logic signed [SAMPLE_W_DEF-1:0] sample;
    logic                           missing;
    logic                           series_end;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W_DEF-1:0] value;
    logic                           was_filled;
    logic                           unfilled;
    logic                           overflow;
    logic                           last_of_run;
  } fill_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // [15:0] sample
  logic              s_axis_tuser  = 1'b0; // missing
  logic              s_axis_tlast  = 1'b0; // series_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [15:0] value
  logic [2:0]        m_axis_tuser;        // was_filled, unfilled, overflow
  logic              m_axis_tlast;        // last_of_run

  sample_item_t samples_to_send[$];
  fill_result_t results_due[$];

  // Shadow of the block's series state
  logic signed [SAMPLE_W_DEF-1:0] last_good = '0;
  bit                             have_good = 1'b0;
  int                             gap_len   = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int samples_in     = 0;
  int results_out    = 0;
  int filled_seen    = 0;
  int unfilled_seen  = 0;
  int overflow_seen  = 0;
  int quiet_cycles   = 0;

  gap_fill_linear_interpolation_core #(
    .MAX_GAP      (MAX_GAP_DEF),
    .SAMPLE_WIDTH (SAMPLE_W_DEF)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  function automatic fill_result_t make_result(input logic [SAMPLE_W_DEF-1:0] v,
                                               input bit filled, input bit unf,
                                               input bit ovf);
    fill_result_t r;
    r.value       = v;
    r.was_filled  = filled;
    r.unfilled    = unf;
    r.overflow    = ovf;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Expected results for one accepted sample; updates the shadow state
  task automatic interpolate_sample(input sample_item_t it);
    longint       prev_v;
    longint       next_v;
    longint       d;
    longint       v;
    fill_result_t burst[$];
    prev_v = longint'(last_good);
    if (!it.missing) begin
      next_v = longint'(it.sample);
      d      = gap_len + 1;
      for (int k = 1; k <= gap_len; k++) begin
        // SV integer division truncates toward zero
        v = have_good ? (prev_v * (d - k) + next_v * k) / d : next_v;
        burst.push_back(make_result(v[SAMPLE_W_DEF-1:0], 1'b1, 1'b0, 1'b0));
      end
      burst.push_back(make_result(it.sample, 1'b0, 1'b0, 1'b0));
      last_good = it.sample;
      have_good = 1'b1;
      gap_len   = 0;
    end else begin
      gap_len = (gap_len + 1) & 63;
      // overflow flush wins over series end
      if (gap_len >= MAX_GAP_DEF || it.series_end) begin
        for (int i = 0; i < gap_len; i++) begin
          if (have_good)
            burst.push_back(make_result(last_good, 1'b1, 1'b0, gap_len >= MAX_GAP_DEF));
          else
            burst.push_back(make_result('0, 1'b0, 1'b1, gap_len >= MAX_GAP_DEF));
        end
        gap_len = 0;
      end
    end
    if (burst.size() > 0)
      burst[burst.size()-1].last_of_run = 1'b1;
    foreach (burst[i])
      results_due.push_back(burst[i]);
    if (it.series_end) begin
      last_good = '0;
      have_good = 1'b0;
      gap_len   = 0;
    end
  endtask

  task automatic add_sample(input logic [SAMPLE_W_DEF-1:0] s, input bit miss, input bit last);
    sample_item_t it;
    it.sample     = s;
    it.missing    = miss;
    it.series_end = last;
    samples_to_send.push_back(it);
  endtask

  // Missing run; the final one optionally closes the series
  task automatic add_missing_run(input int n, input bit end_series);
    for (int i = 0; i < n; i++)
      add_sample(SAMPLE_W_DEF'($urandom), 1'b1, end_series && (i == n - 1));
  endtask

  function automatic logic [SAMPLE_W_DEF-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(SAMPLE_W_DEF-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W_DEF-1){1'b1}}};
      2: return SAMPLE_W_DEF'($urandom_range(15)) - SAMPLE_W_DEF'(8);
      default: return SAMPLE_W_DEF'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(4, 1);
    if (r < 95) return $urandom_range(20, 5);
    return $urandom_range(MAX_GAP_DEF + 1, MAX_GAP_DEF - 8);
  endfunction

  // One well-formed series with random gaps, sometimes a stray item in between
  task automatic add_random_series();
    int segs;
    segs = $urandom_range(6, 1);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(9) == 0)
        add_sample(pick_sample(), 1'($urandom), 1'($urandom));
      add_missing_run(pick_gap(), 1'b0);
      if (s == segs - 1 && $urandom_range(3) == 0)
        add_missing_run($urandom_range(3, 1), 1'b1);
      else
        add_sample(pick_sample(), 1'b0, s == segs - 1);
    end
  endtask

  task automatic drain();
    while (samples_to_send.size() != 0 || results_due.size() != 0 || s_axis_tvalid)
      @(negedge clk);
  endtask

  // Sample driver: predicts on each accepted transaction, then offers the next
  always @(posedge clk) begin : drive_samples
    sample_item_t nxt;
    sample_item_t taken;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.sample     = s_axis_tdata[SAMPLE_W_DEF-1:0];
        taken.missing    = s_axis_tuser;
        taken.series_end = s_axis_tlast;
        interpolate_sample(taken);
        samples_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (samples_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = samples_to_send.pop_front();
          s_axis_tdata  <= DATA_W'(nxt.sample);
          s_axis_tuser  <= nxt.missing;
          s_axis_tlast  <= nxt.series_end;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : check_results
    fill_result_t got;
    fill_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.value       = m_axis_tdata[SAMPLE_W_DEF-1:0];
        got.was_filled  = m_axis_tuser[0];
        got.unfilled    = m_axis_tuser[1];
        got.overflow    = m_axis_tuser[2];
        got.last_of_run = m_axis_tlast;
        results_out++;
        filled_seen   += got.was_filled;
        unfilled_seen += got.unfilled;
        overflow_seen += got.overflow;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result value=%0d filled=%0b unfilled=%0b ovf=%0b last=%0b",
                   $time, got.value, got.was_filled, got.unfilled, got.overflow,
                   got.last_of_run);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected value=%0d filled=%0b unfilled=%0b ovf=%0b last=%0b",
                     $time, want.value, want.was_filled, want.unfilled, want.overflow,
                     want.last_of_run);
            $display("%0t:          actual   value=%0d filled=%0b unfilled=%0b ovf=%0b last=%0b",
                     $time, got.value, got.was_filled, got.unfilled, got.overflow,
                     got.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, results_due.size());
      $display("gap_fill_linear_interpolation_core verification failed");
      $finish;
    end
  end

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, rounding toward zero, copy with no earlier value
    add_sample(16'sh7fff, 1'b0, 1'b0);
    add_missing_run(2, 1'b0);
    add_sample(16'sh8000, 1'b0, 1'b0);
    add_missing_run(1, 1'b0);
    add_sample(16'sh7fff, 1'b0, 1'b0);
    add_sample(-16'sd7, 1'b0, 1'b0);
    add_missing_run(2, 1'b0);
    add_sample(16'sd0, 1'b0, 1'b1);
    add_missing_run(2, 1'b0);
    add_sample(16'sd1234, 1'b0, 1'b0);
    // trailing gap holds the last good value
    add_missing_run(3, 1'b1);
    // whole series missing: unfilled
    add_missing_run(2, 1'b1);
    add_missing_run(1, 1'b1);
    add_sample(16'shffff, 1'b0, 1'b1);
    // full gap together with series end: overflow hold takes precedence
    add_sample(16'sd100, 1'b0, 1'b0);
    add_missing_run(MAX_GAP_DEF, 1'b1);

    // Random series across four flow-control phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // the no-idle phase runs the directed items alone
      if (ph != 0) begin
        goal = samples_to_send.size() + 12;
        while (samples_to_send.size() < goal)
          add_random_series();
      end
      drain();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Sent %0d samples and checked %0d results under four idle/stall mixes",
             samples_in, results_out);
    $display("Results: %0d filled, %0d unfilled, %0d flagged overflow",
             filled_seen, unfilled_seen, overflow_seen);
    if (errors == 0 && results_due.size() == 0)
      $display("gap_fill_linear_interpolation_core verification clean");
    else
      $display("gap_fill_linear_interpolation_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/gfli_pkg.sv
hw/rtl/gfli_div.sv
hw/rtl/gfli_dp.sv
hw/rtl/gfli_ctrl.sv
hw/rtl/gap_fill_linear_interpolation_core.sv
sim/gap_fill_linear_interpolation_core_test.sv
